/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks with reset disable, shared by the core modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds on the same edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/pca_pkg.sv */
// ----------------------------------------------------------------------------
// pca_pkg
// Shared constants, register indexes, state encoding and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pca_pkg;

	// Default sizing
	localparam int MAX_ORDER_DEF      = 8;
	localparam int SAMPLE_BITS_DEF    = 16;
	localparam int COEF_FRAC_BITS_DEF = 16;
	localparam int COEF_INT_BITS      = 8;

	// Configuration port
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE        = 3'd0,
		REG_ORDER       = 3'd1,
		REG_UPPER_LIMIT = 3'd2,
		REG_LOWER_LIMIT = 3'd3,
		REG_COEF_INDEX  = 3'd4,
		REG_COEF_VALUE  = 3'd5
	} pca_reg_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NUM,
		ST_DEN_FF,
		ST_DRAIN_Y,
		ST_CALC_Y,
		ST_DEN_FB,
		ST_DRAIN_FB,
		ST_CALC_FB,
		ST_EMIT
	} pca_state_t;

	// Controller to datapath
	typedef struct packed {
		logic start;    // latch sample, clear accumulator and tap counter
		logic issue;    // multiply one term and step the tap counter
		logic sel_den;  // term from denominator and output history, subtracted
		logic cnt_clr;  // rewind the tap counter
		logic calc_y;   // form the drive value, shift the histories
		logic calc_fb;  // form the new fed-back term
		logic emit;     // load the output register
	} pca_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic mode_aw;
		logic num_last;
		logic den_last;
		logic out_free;
	} pca_sts_t;

endpackage

/* rtl/core/pca_in_if.sv */
// ----------------------------------------------------------------------------
// pca_in_if
// Input sample channel: valid/ready handshake with one sample per word.
// ----------------------------------------------------------------------------
interface pca_in_if #(
	parameter int SAMPLE_BITS = pca_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

/* rtl/core/pca_out_if.sv */
// ----------------------------------------------------------------------------
// pca_out_if
// Output drive channel: valid/ready handshake, drive value and clamp flag.
// ----------------------------------------------------------------------------
interface pca_out_if #(
	parameter int SAMPLE_BITS = pca_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] drive_out;
	logic                          saturated;

	modport source (output valid, output drive_out, output saturated, input ready);
	modport sink   (input valid, input drive_out, input saturated, output ready);
endinterface

/* rtl/core/polynomial_controller_antiwindup_core.sv */
// Sequencing: one sample word at a time; a new word is accepted only in idle,
//   once the previous drive word has gone to the output register.
// Arithmetic: the single shared multiply-accumulate steps through every
//   numerator and denominator tap for each word.
// Reset (arst_n low, asynchronous): histories, fed-back term and coefficients
//   cleared, order 1, plain mode, full-range limits; no clearing pass.
// ----------------------------------------------------------------------------
// polynomial_controller_antiwindup_core
// Polynomial controller with saturation-feedback anti-windup: one error
// sample in, one drive sample and clamp flag out per word.
// ----------------------------------------------------------------------------
module polynomial_controller_antiwindup_core #(
	parameter int MAX_ORDER      = pca_pkg::MAX_ORDER_DEF,
	parameter int SAMPLE_BITS    = pca_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = pca_pkg::COEF_FRAC_BITS_DEF,
	localparam int COEF_W        = pca_pkg::COEF_INT_BITS + COEF_FRAC_BITS,
	localparam int CFG_W         = (COEF_W > SAMPLE_BITS) ? COEF_W : SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pca_in_if.sink                        in_ch,
	pca_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [pca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]              cfg_data
);

	pca_pkg::pca_cmd_t cmd;
	pca_pkg::pca_sts_t sts;

	// Sequencer
	pca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Arithmetic, state and output register
	pca_datapath #(
		.MAX_ORDER      (MAX_ORDER),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.CFG_W          (CFG_W)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.sample_in (in_ch.sample_in),
		.drive_out (out_ch.drive_out),
		.saturated (out_ch.saturated),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

/* rtl/core/pca_ctrl.sv */
// ----------------------------------------------------------------------------
// pca_ctrl
// Sequencer for the shared multiply-accumulate: numerator pass, denominator
// pass, result forming and hand-off to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pca_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pca_pkg::pca_sts_t   sts,
	output pca_pkg::pca_cmd_t   cmd
);

	pca_pkg::pca_state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pca_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pca_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = pca_pkg::ST_NUM;
			end
			pca_pkg::ST_NUM: begin
				if (sts.num_last) begin
					state_nxt = sts.mode_aw ? pca_pkg::ST_DRAIN_Y : pca_pkg::ST_DEN_FF;
				end
			end
			pca_pkg::ST_DEN_FF: begin
				if (sts.den_last) state_nxt = pca_pkg::ST_DRAIN_Y;
			end
			pca_pkg::ST_DRAIN_Y: begin
				state_nxt = pca_pkg::ST_CALC_Y;
			end
			pca_pkg::ST_CALC_Y: begin
				state_nxt = sts.mode_aw ? pca_pkg::ST_DEN_FB : pca_pkg::ST_EMIT;
			end
			pca_pkg::ST_DEN_FB: begin
				if (sts.den_last) state_nxt = pca_pkg::ST_DRAIN_FB;
			end
			pca_pkg::ST_DRAIN_FB: begin
				state_nxt = pca_pkg::ST_CALC_FB;
			end
			pca_pkg::ST_CALC_FB: begin
				state_nxt = pca_pkg::ST_EMIT;
			end
			pca_pkg::ST_EMIT: begin
				if (sts.out_free) state_nxt = pca_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = pca_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			pca_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			pca_pkg::ST_NUM: begin
				cmd.issue   = 1'b1;
				cmd.cnt_clr = sts.num_last;
			end
			pca_pkg::ST_DEN_FF, pca_pkg::ST_DEN_FB: begin
				cmd.issue   = 1'b1;
				cmd.sel_den = 1'b1;
				cmd.cnt_clr = sts.den_last;
			end
			pca_pkg::ST_CALC_Y: begin
				cmd.calc_y = 1'b1;
			end
			pca_pkg::ST_CALC_FB: begin
				cmd.calc_fb = 1'b1;
			end
			pca_pkg::ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`ASSERT_NEXT(a_start_goes_num, clk, arst_n, cmd.start, state_q == pca_pkg::ST_NUM)
	`ASSERT_IMPL(a_emit_needs_room, clk, arst_n, cmd.emit, sts.out_free)

endmodule

/* rtl/core/pca_datapath.sv */
// ----------------------------------------------------------------------------
// pca_datapath
// Configuration registers, coefficient stores, sample histories, the shared
// multiply-accumulate, saturation and limit clamp, and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pca_datapath #(
	parameter int MAX_ORDER      = pca_pkg::MAX_ORDER_DEF,
	parameter int SAMPLE_BITS    = pca_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = pca_pkg::COEF_FRAC_BITS_DEF,
	parameter int CFG_W          = pca_pkg::COEF_INT_BITS + pca_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pca_pkg::pca_cmd_t              cmd,
	output pca_pkg::pca_sts_t              sts,
	input  logic signed [SAMPLE_BITS-1:0]  sample_in,
	output logic signed [SAMPLE_BITS-1:0]  drive_out,
	output logic                           saturated,
	output logic                           out_valid,
	input  logic                           out_ready,
	input  logic                           cfg_we,
	input  logic [pca_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]               cfg_data
);

	localparam int SB      = SAMPLE_BITS;
	localparam int COEF_W  = pca_pkg::COEF_INT_BITS + COEF_FRAC_BITS;
	localparam int PROD_W  = COEF_W + SB;
	localparam int ACC_W   = PROD_W + $clog2(2 * MAX_ORDER + 1) + 1;
	localparam int CW      = $clog2(MAX_ORDER + 1);
	localparam int HW      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int CIDX_W  = $clog2(2 * MAX_ORDER + 1);

	localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-SB+1){1'b1}}, {(SB-1){1'b0}}};

	// Configuration state
	logic                     mode_q;
	logic [CW-1:0]            order_q;
	logic signed [SB-1:0]     upper_q;
	logic signed [SB-1:0]     lower_q;
	logic [CIDX_W-1:0]        coef_idx_q;
	logic signed [COEF_W-1:0] num_q [MAX_ORDER+1];
	logic signed [COEF_W-1:0] den_q [MAX_ORDER];

	// Histories and working registers
	logic signed [SB-1:0]     ih_q [MAX_ORDER];
	logic signed [SB-1:0]     oh_q [MAX_ORDER];
	logic signed [SB-1:0]     fb_q;
	logic signed [SB-1:0]     x_q;
	logic [CW-1:0]            cnt_q;
	logic signed [PROD_W-1:0] p_s1;
	logic                     v_s1;
	logic                     sub_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [SB-1:0]     y_q;
	logic                     flag_q;
	logic                     out_valid_q;
	logic signed [SB-1:0]     drive_q;
	logic                     sat_q;

	logic                     hist_clr;
	logic [CW-1:0]            taps;
	logic [HW-1:0]            idx_h;
	logic [HW-1:0]            idx_m1;
	logic signed [COEF_W-1:0] coef_sel;
	logic signed [SB-1:0]     samp_sel;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc_sh;
	logic signed [SB-1:0]     acc_sat;
	logic signed [SB:0]       sum_fb;
	logic signed [SB:0]       clamp_hi;
	logic signed [SB:0]       clamp_y;
	logic signed [SB-1:0]     y_nxt;
	logic                     flag_nxt;

	assign hist_clr = cfg_we && ((cfg_index == pca_pkg::REG_MODE) ||
	                             (cfg_index == pca_pkg::REG_ORDER));

	// Scalar configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			order_q    <= CW'(1);
			upper_q    <= {1'b0, {(SB-1){1'b1}}};
			lower_q    <= {1'b1, {(SB-1){1'b0}}};
			coef_idx_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pca_pkg::REG_MODE:        mode_q     <= cfg_data[0];
				pca_pkg::REG_ORDER:       order_q    <= cfg_data[CW-1:0];
				pca_pkg::REG_UPPER_LIMIT: upper_q    <= cfg_data[SB-1:0];
				pca_pkg::REG_LOWER_LIMIT: lower_q    <= cfg_data[SB-1:0];
				pca_pkg::REG_COEF_INDEX:  coef_idx_q <= cfg_data[CIDX_W-1:0];
				default: ;
			endcase
		end
	end

	// Coefficient stores; an index past the denominator range stores nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= MAX_ORDER; j++) num_q[j] <= '0;
			for (int j = 0; j < MAX_ORDER; j++) den_q[j] <= '0;
		end else if (cfg_we && (cfg_index == pca_pkg::REG_COEF_VALUE)) begin
			for (int j = 0; j <= MAX_ORDER; j++) begin
				if (coef_idx_q == CIDX_W'(j)) num_q[j] <= cfg_data[COEF_W-1:0];
			end
			for (int j = 0; j < MAX_ORDER; j++) begin
				if (coef_idx_q == CIDX_W'(j + MAX_ORDER + 1)) den_q[j] <= cfg_data[COEF_W-1:0];
			end
		end
	end

	// Taps in use: zero acts as one, anything above the maximum as the maximum
	always_comb begin
		if (order_q == '0) begin
			taps = CW'(1);
		end else if (order_q > CW'(MAX_ORDER)) begin
			taps = CW'(MAX_ORDER);
		end else begin
			taps = order_q;
		end
	end

	assign sts.mode_aw  = mode_q;
	assign sts.num_last = (cnt_q == taps);
	assign sts.den_last = (cnt_q == taps - CW'(1));
	assign sts.out_free = !out_valid_q || out_ready;

	// Tap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start || cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.issue) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// Operand selection
	assign idx_h  = cnt_q[HW-1:0];
	assign idx_m1 = idx_h - HW'(1);

	always_comb begin
		if (cmd.sel_den) begin
			coef_sel = den_q[idx_h];
			samp_sel = oh_q[idx_h];
		end else begin
			coef_sel = num_q[cnt_q];
			samp_sel = (cnt_q == '0) ? x_q : ih_q[idx_m1];
		end
	end

	assign prod = coef_sel * samp_sel;

	// Sample latch
	always_ff @(posedge clk) begin
		if (cmd.start) x_q <= sample_in;
	end

	// Product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			sub_s1 <= 1'b0;
		end else begin
			v_s1   <= cmd.issue;
			sub_s1 <= cmd.sel_den;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) p_s1 <= prod;
	end

	// Accumulator
	always_ff @(posedge clk) begin
		if (cmd.start || cmd.calc_y) begin
			acc_q <= '0;
		end else if (v_s1) begin
			acc_q <= sub_s1 ? acc_q - ACC_W'(p_s1) : acc_q + ACC_W'(p_s1);
		end
	end

	// Floor shift and saturate to the sample range
	assign acc_sh = acc_q >>> COEF_FRAC_BITS;

	always_comb begin
		if (acc_sh > SAT_HI) begin
			acc_sat = {1'b0, {(SB-1){1'b1}}};
		end else if (acc_sh < SAT_LO) begin
			acc_sat = {1'b1, {(SB-1){1'b0}}};
		end else begin
			acc_sat = acc_sh[SB-1:0];
		end
	end

	// Limit clamp: upper first, then lower (signed compares)
	assign sum_fb   = {acc_sat[SB-1], acc_sat} + {fb_q[SB-1], fb_q};
	assign clamp_hi = (sum_fb > $signed({upper_q[SB-1], upper_q})) ?
	                  {upper_q[SB-1], upper_q} : sum_fb;
	assign clamp_y  = (clamp_hi < $signed({lower_q[SB-1], lower_q})) ?
	                  {lower_q[SB-1], lower_q} : clamp_hi;

	always_comb begin
		if (mode_q) begin
			y_nxt    = clamp_y[SB-1:0];
			flag_nxt = (clamp_y != sum_fb);
		end else begin
			y_nxt    = acc_sat;
			flag_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_y) begin
			y_q    <= y_nxt;
			flag_q <= flag_nxt;
		end
	end

	// Histories and fed-back term
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_ORDER; j++) begin
				ih_q[j] <= '0;
				oh_q[j] <= '0;
			end
			fb_q <= '0;
		end else if (hist_clr) begin
			for (int j = 0; j < MAX_ORDER; j++) begin
				ih_q[j] <= '0;
				oh_q[j] <= '0;
			end
			fb_q <= '0;
		end else if (cmd.calc_y) begin
			for (int j = MAX_ORDER - 1; j > 0; j--) begin
				ih_q[j] <= ih_q[j-1];
				oh_q[j] <= oh_q[j-1];
			end
			ih_q[0] <= x_q;
			oh_q[0] <= y_nxt;
		end else if (cmd.calc_fb) begin
			fb_q <= acc_sat;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			drive_q <= y_q;
			sat_q   <= flag_q;
		end
	end

	assign out_valid = out_valid_q;
	assign drive_out = drive_q;
	assign saturated = sat_q;

	`ASSERT_IMPL(a_calc_after_drain, clk, arst_n, cmd.calc_y || cmd.calc_fb, !v_s1)
	`ASSERT_IMPL(a_tap_in_range, clk, arst_n, cmd.issue, cnt_q <= taps)
	`ASSERT_NEXT(a_clamp_in_limits, clk, arst_n, cmd.calc_y && mode_q && (lower_q <= upper_q), (y_q <= upper_q) && (y_q >= lower_q))

endmodule

/* test/pca_checker.sv */
// ----------------------------------------------------------------------------
// pca_checker
// Watches the config port and both channels of the controller core, keeps
// its own copy of the controller state, predicts one drive word per accepted
// sample word and compares each drive word field by field.
// ----------------------------------------------------------------------------
module pca_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic signed [15:0]            sample_in,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic signed [15:0]            drive_out,
	input  logic                          saturated,
	input  logic                          cfg_we,
	input  logic [pca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [23:0]                   cfg_data,
	output int                            pending,
	output int                            fail_count
);
	import pca_pkg::*;

	localparam int MAX_TAPS = MAX_ORDER_DEF;
	localparam int FRAC     = COEF_FRAC_BITS_DEF;

	typedef struct {
		logic signed [15:0] drive;
		logic               sat;
	} drive_word_t;

	// Controller copy: registers, coefficient stores and histories
	logic               aw_mode;
	logic [3:0]         order;
	logic signed [15:0] upper, lower;
	logic [4:0]         coef_sel;
	logic signed [23:0] num [0:MAX_TAPS];
	logic signed [23:0] den [0:MAX_TAPS-1];
	logic signed [15:0] x_hist [0:MAX_TAPS-1];
	logic signed [15:0] y_hist [0:MAX_TAPS-1];
	longint             fb_term;

	drive_word_t drive_q[$];
	int          fails;
	int          words;

	function automatic longint clamp_sample(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic void clear_histories();
		int i;
		for (i = 0; i < MAX_TAPS; i++) begin
			x_hist[i] = '0;
			y_hist[i] = '0;
		end
		fb_term = 0;
	endfunction

	function automatic void reset_model();
		int i;
		aw_mode  = 1'b0;
		order    = 4'd1;
		upper    = 16'sd32767;
		lower    = -16'sd32768;
		coef_sel = '0;
		for (i = 0; i <= MAX_TAPS; i++)
			num[i] = '0;
		for (i = 0; i < MAX_TAPS; i++)
			den[i] = '0;
		clear_histories();
	endfunction

	function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
		case (idx)
			REG_MODE: begin
				aw_mode = data[0];
				clear_histories();
			end
			REG_ORDER: begin
				order = data[3:0];
				clear_histories();
			end
			REG_UPPER_LIMIT: upper = data[15:0];
			REG_LOWER_LIMIT: lower = data[15:0];
			REG_COEF_INDEX:  coef_sel = data[4:0];
			REG_COEF_VALUE: begin
				// indexes past the denominator store write nothing
				if (coef_sel <= MAX_TAPS)
					num[coef_sel] = data;
				else if (coef_sel <= 2 * MAX_TAPS)
					den[coef_sel - MAX_TAPS - 1] = data;
			end
			default: ;
		endcase
	endfunction

	// One control step: drive word for sample x, histories advanced
	function automatic drive_word_t control_step(input logic signed [15:0] x);
		drive_word_t w;
		longint      acc, s, y;
		int          n, i;
		n = (order == 0) ? 1 : (order > MAX_TAPS) ? MAX_TAPS : int'(order);
		acc = longint'(num[0]) * longint'(x);
		for (i = 1; i <= n; i++)
			acc += longint'(num[i]) * longint'(x_hist[i-1]);
		w.sat = 1'b0;
		if (aw_mode) begin
			// clamp upper first, then lower (crossed limits end at lower)
			s = clamp_sample(acc >>> FRAC) + fb_term;
			y = s;
			if (y > upper)
				y = upper;
			if (y < lower)
				y = lower;
			w.sat = (y != s);
			for (i = MAX_TAPS - 1; i > 0; i--)
				y_hist[i] = y_hist[i-1];
			y_hist[0] = y[15:0];
			acc = 0;
			for (i = 0; i < n; i++)
				acc -= longint'(den[i]) * longint'(y_hist[i]);
			fb_term = clamp_sample(acc >>> FRAC);
		end else begin
			for (i = 1; i <= n; i++)
				acc -= longint'(den[i-1]) * longint'(y_hist[i-1]);
			y = clamp_sample(acc >>> FRAC);
			for (i = MAX_TAPS - 1; i > 0; i--)
				y_hist[i] = y_hist[i-1];
			y_hist[0] = y[15:0];
		end
		for (i = MAX_TAPS - 1; i > 0; i--)
			x_hist[i] = x_hist[i-1];
		x_hist[0] = x;
		w.drive = y[15:0];
		return w;
	endfunction

	// Track config, predict on sample words, compare drive words
	always @(posedge clk or negedge arst_n) begin
		drive_word_t want;
		if (!arst_n) begin
			reset_model();
			drive_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				drive_q.push_back(control_step(sample_in));
			if (out_valid && out_ready) begin
				if (drive_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("word %0d: drive %0d sat %0b with nothing expected",
							words, drive_out, saturated);
				end else begin
					want = drive_q.pop_front();
					if (want.drive !== drive_out || want.sat !== saturated) begin
						fails++;
						if (fails <= 10)
							$display("word %0d: drive exp %0d got %0d, sat exp %0b got %0b",
								words, want.drive, drive_out, want.sat, saturated);
					end
				end
				words++;
			end
			pending    <= drive_q.size();
			fail_count <= fails;
		end
	end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the polynomial controller core: a directed pass over the
// field extremes, both modes, limit clamps, crossed limits, order and index
// out of range and history clears, then random phases with random config.
// Both channel sides idle at random; the checker judges every drive word.
// ----------------------------------------------------------------------------
module tb;
	import pca_pkg::*;

	localparam int MAX_TAPS    = MAX_ORDER_DEF;
	localparam int RX_HOLD     = 300;
	localparam int SETTLE      = 2 * MAX_TAPS + 12;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES      = 24;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [23:0]          cfg_data;
	logic                 calm;
	int                   pending;
	int                   fail_count;
	int                   cycles;
	int                   hold_token;
	int                   hold_seen;

	pca_in_if  in_ch ();
	pca_out_if out_ch ();

	polynomial_controller_antiwindup_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pca_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.sample_in  (in_ch.sample_in),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.drive_out  (out_ch.drive_out),
		.saturated  (out_ch.saturated),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Drive word receiver: random idles, one long hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				out_ch.ready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else if (!calm && $urandom_range(99) < 7) begin
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic put_reg(input pca_reg_t r, input int v);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v[23:0];
		@(posedge clk);
	endtask

	task automatic put_coef(input int k, input int v);
		put_reg(REG_COEF_INDEX, k);
		put_reg(REG_COEF_VALUE, v);
	endtask

	task automatic send_word(input logic signed [15:0] v);
		cfg_we <= 1'b0;
		if (!calm && $urandom_range(99) < 7) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.sample_in <= v;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// Sender pause until every predicted drive word has come back
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_sample();
		int v;
		case ($urandom_range(3))
			0:       v = $urandom();
			1:       v = $urandom_range(512) - 256;
			2:       v = $urandom_range(8192) - 4096;
			default: v = $urandom_range(1) ? 32767 : -32768;
		endcase
		return v[15:0];
	endfunction

	function automatic int rand_coef();
		int v;
		case ($urandom_range(3))
			0:       v = $urandom();                      // full Q8.16 range
			1:       v = $urandom_range(131072) - 65536;  // within +/-1.0
			default: v = $urandom_range(32768) - 16384;
		endcase
		return v;
	endfunction

	// hold_rx: receiver holds off while this phase's words are offered
	task automatic random_phase(input int n_words, input bit hold_rx);
		int hi, lo, k;
		drain();
		if ($urandom_range(3) != 0) begin
			put_reg(REG_MODE, $urandom_range(1));
			put_reg(REG_ORDER, ($urandom_range(7) == 0) ? $urandom_range(15)
				: $urandom_range(MAX_TAPS, 1));
		end
		case ($urandom_range(3))
			0: begin
				hi = 32767;
				lo = -32768;
			end
			1: begin
				hi = $urandom_range(20000);
				lo = -$urandom_range(20000);
			end
			2: begin
				// may cross
				hi = $urandom();
				lo = $urandom();
			end
			default: begin
				hi = $urandom_range(3000);
				lo = hi - $urandom_range(6000);
			end
		endcase
		put_reg(REG_UPPER_LIMIT, hi);
		put_reg(REG_LOWER_LIMIT, lo);
		for (k = 0; k <= 2 * MAX_TAPS; k++)
			if ($urandom_range(2) != 0)
				put_coef(k, rand_coef());
		if ($urandom_range(3) == 0)
			put_coef($urandom_range(31, 2 * MAX_TAPS + 1), $urandom());
		if (hold_rx)
			hold_token <= hold_token + 1;
		repeat (n_words)
			send_word(rand_sample());
	endtask

	initial begin
		int ph;
		arst_n          <= 1'b0;
		in_ch.valid     <= 1'b0;
		in_ch.sample_in <= '0;
		cfg_we          <= 1'b0;
		cfg_index       <= REG_MODE;
		cfg_data        <= '0;
		calm            <= 1'b0;
		hold_token      <= 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset config: plain mode, order 1, zero coefficients
		send_word(16'sd32767);
		send_word(-16'sd32768);

		// Unity gain, then extreme coefficients driving the sum into saturation
		drain();
		put_coef(0, 32'h010000);
		send_word(16'sd32767);
		send_word(-16'sd32768);
		send_word(-16'sd1);
		drain();
		put_coef(0, 32'h7FFFFF);
		put_coef(1, -32'h800000);
		send_word(16'sd32767);
		send_word(16'sd100);
		send_word(-16'sd32768);

		// Plain recursion with den[0] = -0.5
		drain();
		put_coef(0, 32'h010000);
		put_coef(1, 0);
		put_coef(MAX_TAPS + 1, -32'h8000);
		put_reg(REG_ORDER, 1);
		send_word(16'sd1000);
		send_word(16'sd0);
		send_word(16'sd0);

		// Rewriting the same order still clears the histories
		drain();
		put_reg(REG_ORDER, 1);
		send_word(16'sd0);

		// Anti-windup form: clamp at both limits, fed-back term in between
		drain();
		put_reg(REG_MODE, 1);
		put_reg(REG_UPPER_LIMIT, 1000);
		put_reg(REG_LOWER_LIMIT, -1000);
		put_coef(MAX_TAPS + 1, 32'h4000);
		send_word(16'sd32767);
		send_word(16'sd0);
		send_word(-16'sd32768);

		// Crossed limits end at the lower limit
		drain();
		put_reg(REG_UPPER_LIMIT, -100);
		put_reg(REG_LOWER_LIMIT, 100);
		send_word(16'sd5);

		// Order zero acts as one, order above the maximum as the maximum
		drain();
		put_reg(REG_UPPER_LIMIT, 32767);
		put_reg(REG_LOWER_LIMIT, -32768);
		put_reg(REG_ORDER, 0);
		send_word(16'sd300);
		drain();
		put_coef(MAX_TAPS, 32'h010000);
		put_coef(2 * MAX_TAPS, -32'h2000);
		put_reg(REG_ORDER, 15);
		send_word(16'sd12345);
		send_word(-16'sd2222);

		// Coefficient index past the store, mode rewritten with same value
		drain();
		put_coef(31, 32'h123456);
		put_coef(2 * MAX_TAPS + 1, 32'h7FFFFF);
		put_reg(REG_MODE, 1);
		send_word(16'sd4321);

		// Random phases: calm stretch with no idling, one long receiver hold
		for (ph = 0; ph < PHASES; ph++) begin
			calm <= (ph >= 8 && ph < 12);
			if (ph == 5)
				random_phase(30, 1'b1);
			else
				random_phase($urandom_range(28, 8), 1'b0);
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
